// ===== rtl/core/egqt_pkg.sv =====
// Package for the epsilon-greedy action-value table unit.
// Holds field widths, parameter defaults, item kind codes and shared helpers.
// No dependencies.
package egqt_pkg;

    localparam int DEF_NUM_STATES  = 5;
    localparam int DEF_NUM_ACTIONS = 5;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int STATE_W     = 3;
    localparam int ACTION_W    = 3;
    localparam int NEWVAL_W    = 32;
    localparam int FRAC_W      = 16;
    localparam int THRESH_W    = 17;
    localparam int ROWMAX_W    = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 17'd58982;

    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Side information of a select item while its row is read.
    typedef struct packed {
        logic              in_range;
        logic [FRAC_W-1:0] frac;
        logic [ACTION_W-1:0] ract;
    } sel_info_t;

    // Reduces a three-bit action modulo the number of actions (at least two).
    function automatic logic [ACTION_W-1:0] wrap_action(logic [ACTION_W-1:0] a, int n);
        int v;
        v = int'(a);
        for (int i = 0; i < 4; i++) begin
            if (v >= n) begin
                v = v - n;
            end
        end
        return ACTION_W'(v);
    endfunction

endpackage

// ===== rtl/core/egqt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module egqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/epsilon_greedy_q_table_unit.sv =====
// Top level of the epsilon-greedy action-value table unit.
// Depends on egqt_pkg and egqt_ram.
//
// The unit accepts one item per cycle. An update word writes one table entry and
// gives no result. A select word reads its whole row at once from one RAM per
// action column, and its result stands in the output register after the
// word is accepted: the registered RAM read happens at the accepting edge, and the
// compare tree and the choice fill the output register at a later edge on which the
// pipeline advances. Back-pressure on the result side stalls the whole pipeline.
// After reset the table is cleared by a pass over all NUM_STATES rows, one row a cycle,
// during which s_tready is low; the threshold register can be written at any time.
module epsilon_greedy_q_table_unit
    import egqt_pkg::*;
#(
    parameter int NUM_STATES  = DEF_NUM_STATES,
    parameter int NUM_ACTIONS = DEF_NUM_ACTIONS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Threshold register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [THRESH_W-1:0]    cfg_data,
    // Input words.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // state_index[2:0], action_index[5:3], new_value[37:6],
    // random_fraction[53:38], random_action[56:54], zero[63:57]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                   s_tuser,
    // Result words.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // chosen_action[2:0], row_maximum[34:3], explored[35], zero[39:36]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(NUM_STATES);
    localparam int IDX_W  = $clog2(NUM_ACTIONS);
    localparam int POW    = 1 << IDX_W;

    // Input field extraction.
    logic                    in_kind;
    logic [STATE_W-1:0]      in_state;
    logic [ACTION_W-1:0]     in_action;
    logic [NEWVAL_W-1:0]     in_value;
    logic [FRAC_W-1:0]       in_frac;
    logic [ACTION_W-1:0]     in_ract;

    assign in_kind   = s_tuser;
    assign in_state  = s_tdata[2:0];
    assign in_action = s_tdata[5:3];
    assign in_value  = s_tdata[37:6];
    assign in_frac   = s_tdata[53:38];
    assign in_ract   = s_tdata[56:54];

    logic [THRESH_W-1:0] thresh_reg;
    logic                clr_busy_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                p1_valid_reg;
    sel_info_t           p1_info_reg;
    logic                m_valid_reg;
    logic [ACTION_W-1:0] m_action_reg;
    logic [ROWMAX_W-1:0] m_max_reg;
    logic                m_explored_reg;

    logic                advance;
    logic                s_accept;
    logic                state_ok;
    logic                action_ok;
    logic [ADDR_W-1:0]   ram_addr;
    logic [VALUE_WIDTH-1:0] wr_value;

    // The pipeline moves whenever the output register is free or being emptied.
    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !clr_busy_reg && advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign state_ok  = 32'(in_state) < NUM_STATES;
    assign action_ok = 32'(in_action) < NUM_ACTIONS;
    assign ram_addr  = clr_busy_reg ? clr_addr_reg : ADDR_W'(in_state);
    assign wr_value  = clr_busy_reg ? '0 : VALUE_WIDTH'($signed(in_value));

    // One RAM per action column, all read at the same row.
    logic [VALUE_WIDTH-1:0] lane_rd [NUM_ACTIONS];

    for (genvar g = 0; g < NUM_ACTIONS; g++) begin : g_lane
        logic lane_we;
        assign lane_we = clr_busy_reg
            || (s_accept && in_kind == KIND_UPDATE && state_ok && action_ok
                && 32'(in_action) == g);
        egqt_ram #(
            .WIDTH (VALUE_WIDTH),
            .DEPTH (NUM_STATES)
        ) u_ram (
            .clk   (aclk),
            .we    (lane_we),
            .waddr (ram_addr),
            .wdata (wr_value),
            .re    (s_accept && in_kind == KIND_SELECT && state_ok),
            .raddr (ADDR_W'(in_state)),
            .rdata (lane_rd[g])
        );
    end

    // Row maximum and first index of it, as a tree; the left child wins ties.
    logic signed [VALUE_WIDTH-1:0] node_val [1:2*POW-1];
    logic [IDX_W-1:0]              node_idx [1:2*POW-1];
    logic                          node_ok  [1:2*POW-1];

    always_comb begin : p_tree
        logic take_r;
        take_r = 1'b0;
        for (int i = 0; i < POW; i++) begin
            node_ok[POW+i]  = (i < NUM_ACTIONS);
            node_idx[POW+i] = IDX_W'(i);
            if (i < NUM_ACTIONS) begin
                node_val[POW+i] = lane_rd[i];
            end else begin
                node_val[POW+i] = '0;
            end
        end
        for (int n = POW - 1; n >= 1; n--) begin
            take_r = node_ok[2*n+1]
                && (!node_ok[2*n] || node_val[2*n] < node_val[2*n+1]);
            node_ok[n]  = node_ok[2*n] || node_ok[2*n+1];
            node_val[n] = take_r ? node_val[2*n+1] : node_val[2*n];
            node_idx[n] = take_r ? node_idx[2*n+1] : node_idx[2*n];
        end
    end

    logic                greedy;
    logic [ACTION_W-1:0] action_next;
    logic [ROWMAX_W-1:0] max_next;
    logic                explored_next;

    always_comb begin
        greedy        = {1'b0, p1_info_reg.frac} < thresh_reg;
        action_next   = '0;
        max_next      = '0;
        explored_next = 1'b0;
        if (p1_info_reg.in_range) begin
            max_next = ROWMAX_W'(node_val[1]);
            if (greedy) begin
                action_next = ACTION_W'(node_idx[1]);
            end else begin
                action_next   = wrap_action(p1_info_reg.ract, NUM_ACTIONS);
                explored_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= THRESHOLD_RESET;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            if (clr_busy_reg) begin
                if (clr_addr_reg == ADDR_W'(NUM_STATES - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (advance) begin
                p1_valid_reg <= s_accept && in_kind == KIND_SELECT;
                m_valid_reg  <= p1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_info_reg.in_range <= state_ok;
            p1_info_reg.frac     <= in_frac;
            p1_info_reg.ract     <= in_ract;
            m_action_reg         <= action_next;
            m_max_reg            <= max_next;
            m_explored_reg       <= explored_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_explored_reg, m_max_reg, m_action_reg};

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready)
        else $error("input accepted during the clearing pass");

    a_clear_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> (32'(clr_addr_reg) < NUM_STATES))
        else $error("clearing address beyond the table");

    a_select_enters_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_kind == KIND_SELECT) |=> p1_valid_reg)
        else $error("select word lost on entry");

    a_update_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_kind == KIND_UPDATE) |=> !p1_valid_reg)
        else $error("update word produced a result");

    a_action_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (32'(m_action_reg) < NUM_ACTIONS))
        else $error("chosen action out of range");
`endif

endmodule
